// File: hdl/f2p24_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2p24_pkg: shared types and constants for the float to PCM24 WAV framer
// Holds the queue entry type, header constants and field widths.
// ----------------------------------------------------------------------------
package f2p24_pkg;

	localparam int unsigned RATE_W  = 20;
	localparam int unsigned CHAN_W  = 7;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned PCM_W   = 24;
	localparam int unsigned HDR_LEN = 44;

	localparam logic [23:0] PCM_MAX = 24'd8388607;

	localparam logic [1:0] REG_RATE = 2'd0;
	localparam logic [1:0] REG_CHAN = 2'd1;
	localparam logic [1:0] REG_LEN  = 2'd2;

	// one entry of the queue between front and back
	typedef struct packed {
		logic             hdr;
		logic [PCM_W-1:0] pcm;
	} item_t;

endpackage : f2p24_pkg
`default_nettype wire

// File: hdl/f2p24_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2p24_front: sample conversion pipeline
// Three-stage conversion of a single-precision word to a saturated PCM24 value.
// Stage 1 multiplies the significand by 8388607, stage 2 rounds to 24
// significant bits, stage 3 rounds to integer and saturates. Headers pass
// through with a flag.
// ----------------------------------------------------------------------------
module f2p24_front import f2p24_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] sample_bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output item_t            out_item
);

	logic        v_s1, v_s2, v_s3;
	logic        hdr_s1, neg_s1, zero_s1, sat_s1;
	logic [47:0] prod_s1;
	logic [7:0]  shift_s1;
	logic        hdr_s2, neg_s2, zero_s2, sat_s2;
	logic [47:0] p24_s2;
	logic [8:0]  sh2_s2;
	item_t       item_s3;

	logic        adv_s3, adv_s2, adv_s1;
	logic [7:0]  expo;
	logic [22:0] mant;
	logic [23:0] sig;

	assign expo = sample_bits[30:23];
	assign mant = sample_bits[22:0];
	assign sig  = (expo == 8'd0) ? {1'b0, mant} : {1'b1, mant};

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			hdr_s1   <= kind;
			neg_s1   <= sample_bits[31];
			zero_s1  <= (expo == 8'hFF && mant != 23'd0) || sig == 24'd0;
			sat_s1   <= expo >= 8'd127;
			prod_s1  <= 48'(sig) * 48'(PCM_MAX);
			shift_s1 <= (expo == 8'd0) ? 8'd149 : 8'(8'd150 - expo);
		end
	end

	// stage 2: round to 24 significant bits
	logic [5:0]  len;
	logic [5:0]  drop;
	logic [47:0] q1, rem1, half1, p24;
	logic [8:0]  sh2;

	always_comb begin
		len = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (prod_s1[i]) len = 6'(i + 1);
		end
		drop  = (len > 6'd24) ? 6'(len - 6'd24) : 6'd0;
		q1    = prod_s1 >> drop;
		rem1  = prod_s1 & ((48'd1 << drop) - 48'd1);
		half1 = (drop == 6'd0) ? 48'd0 : (48'd1 << (drop - 6'd1));
		p24   = q1;
		if (drop != 6'd0 && (rem1 > half1 || (rem1 == half1 && q1[0]))) p24 = q1 + 48'd1;
		sh2   = 9'({1'b0, shift_s1}) - 9'(drop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			hdr_s2  <= hdr_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			sat_s2  <= sat_s1;
			p24_s2  <= p24;
			sh2_s2  <= sh2;
		end
	end

	// stage 3: round to integer, saturate, apply sign
	logic [47:0] q2, rem2, half2, rnd;
	logic [23:0] mag, res;

	always_comb begin
		rnd = p24_s2;
		q2 = 48'd0; rem2 = 48'd0; half2 = 48'd0;
		if (!sh2_s2[8] && sh2_s2 != 9'd0) begin
			if (sh2_s2 > 9'd47) begin
				rnd = 48'd0;
			end else begin
				q2    = p24_s2 >> sh2_s2[5:0];
				rem2  = p24_s2 & ((48'd1 << sh2_s2[5:0]) - 48'd1);
				half2 = 48'd1 << (sh2_s2[5:0] - 6'd1);
				rnd   = q2;
				if (rem2 > half2 || (rem2 == half2 && q2[0])) rnd = q2 + 48'd1;
			end
		end
		if (sat_s2 || rnd > 48'(PCM_MAX)) mag = PCM_MAX;
		else mag = rnd[23:0];
		if (zero_s2) res = 24'd0;
		else res = neg_s2 ? 24'(-mag) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			item_s3.hdr <= hdr_s2;
			item_s3.pcm <= res;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule : f2p24_front
`default_nettype wire

// File: hdl/f2p24_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2p24_fifo: short queue between front and back
// Two-entry register queue so front and back stall independently.
// ----------------------------------------------------------------------------
module f2p24_fifo import f2p24_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	input  wire item_t wr_item,
	output logic       rd_valid,
	input  wire logic  rd_ready,
	output item_t      rd_item
);

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

endmodule : f2p24_fifo
`default_nettype wire

// File: hdl/f2p24_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2p24_back: byte serialiser
// Emits three PCM bytes or the 44-byte header from a byte counter, into a
// skid-free output register.
// ----------------------------------------------------------------------------
module f2p24_back import f2p24_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire item_t             in_item,
	input  wire logic [RATE_W-1:0] sample_rate,
	input  wire logic [CHAN_W-1:0] channel_count,
	input  wire logic [LEN_W-1:0]  data_bytes,
	input  wire logic [31:0]       byte_rate,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_last
);

	logic [5:0]  idx_q;
	logic        vld_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        load;
	logic        fin;
	logic [7:0]  b;
	logic [31:0] riff;
	logic [15:0] blk;

	assign load = !vld_q || out_ready;
	assign fin  = in_item.hdr ? (idx_q == 6'(HDR_LEN - 1)) : (idx_q == 6'd2);
	assign in_ready = load && fin;
	assign riff = data_bytes + 32'd36;
	assign blk  = 16'(channel_count) * 16'd3;

	always_comb begin
		b = 8'h00;
		if (!in_item.hdr) begin
			case (idx_q[1:0])
				2'd0:    b = in_item.pcm[7:0];
				2'd1:    b = in_item.pcm[15:8];
				default: b = in_item.pcm[23:16];
			endcase
		end else begin
			case (idx_q)
				6'd0:  b = 8'h52;
				6'd1:  b = 8'h49;
				6'd2:  b = 8'h46;
				6'd3:  b = 8'h46;
				6'd4:  b = riff[7:0];
				6'd5:  b = riff[15:8];
				6'd6:  b = riff[23:16];
				6'd7:  b = riff[31:24];
				6'd8:  b = 8'h57;
				6'd9:  b = 8'h41;
				6'd10: b = 8'h56;
				6'd11: b = 8'h45;
				6'd12: b = 8'h66;
				6'd13: b = 8'h6D;
				6'd14: b = 8'h74;
				6'd15: b = 8'h20;
				6'd16: b = 8'd16;
				6'd20: b = 8'd1;
				6'd22: b = 8'(channel_count);
				6'd24: b = sample_rate[7:0];
				6'd25: b = sample_rate[15:8];
				6'd26: b = 8'(sample_rate[19:16]);
				6'd28: b = byte_rate[7:0];
				6'd29: b = byte_rate[15:8];
				6'd30: b = byte_rate[23:16];
				6'd31: b = byte_rate[31:24];
				6'd32: b = blk[7:0];
				6'd33: b = blk[15:8];
				6'd34: b = 8'd24;
				6'd36: b = 8'h64;
				6'd37: b = 8'h61;
				6'd38: b = 8'h74;
				6'd39: b = 8'h61;
				6'd40: b = data_bytes[7:0];
				6'd41: b = data_bytes[15:8];
				6'd42: b = data_bytes[23:16];
				6'd43: b = data_bytes[31:24];
				default: b = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 6'd0;
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= in_valid;
			if (in_valid) idx_q <= fin ? 6'd0 : 6'(idx_q + 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_q <= b;
			last_q <= fin;
		end
	end

	assign out_valid = vld_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule : f2p24_back
`default_nettype wire

// File: hdl/float_to_pcm24_wav_framer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float_to_pcm24_wav_framer_core: float32 to PCM24 converter and WAV framer
// A sample word (tuser 0) becomes three little-endian PCM24 bytes, the third
// marked with tlast; a header word (tuser 1) becomes the 44-byte PCM WAV
// header from the configured rate, channels and data length. The output
// channel moves one byte per cycle while m_tready is high, a rate the byte
// serialiser sets. Conversion runs in a three-stage pipeline feeding a
// two-entry queue, so input keeps flowing while bytes drain. A first byte
// is valid after its word passes the stages, queue and output register.
// ----------------------------------------------------------------------------
module float_to_pcm24_wav_framer_core import f2p24_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample_bits
	input  wire logic        s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [RATE_W-1:0] rate_q;
	logic [CHAN_W-1:0] chan_q;
	logic [LEN_W-1:0]  len_q;
	logic [31:0]       rate3_q, brate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(48000);
			chan_q <= CHAN_W'(2);
			len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE: rate_q <= cfg_data[RATE_W-1:0];
				REG_CHAN: chan_q <= cfg_data[CHAN_W-1:0];
				REG_LEN:  len_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	// byte rate, two registered steps
	always_ff @(posedge clk) begin
		rate3_q <= 32'(rate_q) * 32'd3;
		brate_q <= rate3_q * 32'(chan_q);
	end

	item_t f_item, q_item;
	logic  f_valid, f_ready, q_valid, q_ready;

	f2p24_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.kind(s_tuser), .sample_bits(s_tdata),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	f2p24_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	f2p24_back u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.sample_rate(rate_q), .channel_count(chan_q), .data_bytes(len_q),
		.byte_rate(brate_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_byte(m_tdata), .out_last(m_tlast)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");
	a_nolast_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |-> (u_back.idx_q == 6'd2 || u_back.idx_q == 6'(HDR_LEN - 1)))
		else $error("queue entry released before its last byte");

endmodule : float_to_pcm24_wav_framer_core
`default_nettype wire

// File: tb/sv/float_to_pcm24_wav_framer_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float_to_pcm24_wav_framer_core_tb: self-checking bench for the PCM24 framer
// Feeds sample and header words under random gaps and output stalls. It
// predicts every output byte from its own float to PCM24 conversion and WAV
// header builder, and runs across several register settings.
// ----------------------------------------------------------------------------
module float_to_pcm24_wav_framer_core_tb;
	import f2p24_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        hdr;
		logic [31:0] bits;
	} word_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	word_t pending_words[$];
	out_t  bytes_due[$];
	logic [RATE_W-1:0] rate_sh;
	logic [CHAN_W-1:0] chan_sh;
	logic [LEN_W-1:0]  len_sh;
	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit tx_fired = 1'b0;

	float_to_pcm24_wav_framer_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [23:0] to_pcm24(input logic [31:0] bits);
		logic [7:0]  ex;
		logic [22:0] mt;
		logic [63:0] sig, prod, q, rem, half, rnd;
		int sh, len, drop;
		logic [23:0] mag;
		ex = bits[30:23];
		mt = bits[22:0];
		if (ex == 8'hFF && mt != 0) return 24'd0;
		if (ex >= 8'd127) begin
			mag = PCM_MAX;
		end else begin
			if (ex == 0) begin
				sig = {41'd0, mt};
				sh = 149;
			end else begin
				sig = {40'd0, 1'b1, mt};
				sh = 150 - int'(ex);
			end
			if (sig == 0) return 24'd0;
			prod = sig * 64'd8388607;
			len = 0;
			while (len < 63 && (prod >> len) != 0) len++;
			if (len > 24) begin
				drop = len - 24;
				q = prod >> drop;
				rem = prod & ((64'd1 << drop) - 1);
				half = 64'd1 << (drop - 1);
				if (rem > half || (rem == half && q[0])) q++;
				prod = q;
				sh -= drop;
			end
			if (sh <= 0) begin
				rnd = prod;
			end else if (sh > 62) begin
				rnd = 0;
			end else begin
				q = prod >> sh;
				rem = prod & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0])) q++;
				rnd = q;
			end
			if (rnd > 64'd8388607) rnd = 64'd8388607;
			mag = rnd[23:0];
		end
		return bits[31] ? -mag : mag;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		out_t o;
		o.b = b;
		o.last = last;
		bytes_due.push_back(o);
	endtask

	task automatic predict_word(input word_t w);
		logic [7:0] hb[HDR_LEN];
		logic [31:0] f[11];
		logic [23:0] p;
		if (!w.hdr) begin
			p = to_pcm24(w.bits);
			push_byte(p[7:0], 1'b0);
			push_byte(p[15:8], 1'b0);
			push_byte(p[23:16], 1'b1);
		end else begin
			f[0] = 32'h46464952;
			f[1] = len_sh + 32'd36;
			f[2] = 32'h45564157;
			f[3] = 32'h20746d66;
			f[4] = 32'd16;
			f[5] = {9'd0, chan_sh, 16'd1};
			f[6] = {12'd0, rate_sh};
			f[7] = {12'd0, rate_sh} * 32'd3 * {25'd0, chan_sh};
			f[8] = {16'd24, 16'(32'd3 * {25'd0, chan_sh})};
			f[9] = 32'h61746164;
			f[10] = len_sh;
			for (int i = 0; i < HDR_LEN; i++) hb[i] = f[i / 4][8 * (i % 4) +: 8];
			for (int i = 0; i < HDR_LEN; i++) push_byte(hb[i], i == HDR_LEN - 1);
		end
	endtask

	always @(posedge clk) begin
		word_t w;
		out_t o;
		if (s_tvalid && s_tready) begin
			w.hdr = s_tuser;
			w.bits = s_tdata;
			predict_word(w);
			tx_fired = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			if (bytes_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected byte %h last %b", m_tdata, m_tlast);
			end else begin
				o = bytes_due.pop_front();
				if (o.b !== m_tdata || o.last !== m_tlast) begin
					errors++;
					if (errors <= 10)
						$display("byte mismatch: exp %h/%b got %h/%b", o.b, o.last,
							m_tdata, m_tlast);
				end
			end
		end
	end

	always @(negedge clk) begin
		logic v;
		word_t w;
		v = s_tvalid;
		if (tx_fired) begin
			tx_fired = 1'b0;
			v = 1'b0;
			tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		end
		if (!v && arst_n) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				s_tdata <= w.bits;
				s_tuser <= w.hdr;
				v = 1'b1;
			end
		end
		s_tvalid <= v;
	end

	always @(negedge clk) begin
		logic r;
		r = 1'b0;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
		end else if (rx_gap > 0) begin
			rx_gap--;
		end else begin
			r = 1'b1;
			if (m_tvalid && m_tready)
				rx_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
		end
		m_tready <= r;
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RATE: rate_sh = val[RATE_W-1:0];
			REG_CHAN: chan_sh = val[CHAN_W-1:0];
			REG_LEN:  len_sh = val;
			default: ;
		endcase
	endtask

	task automatic add_word(input logic hdr, input logic [31:0] bits);
		word_t w;
		w.hdr = hdr;
		w.bits = bits;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || s_tvalid || bytes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_bits();
		logic [31:0] b;
		b = $urandom;
		if ($urandom_range(0, 1)) b[30:23] = 8'($urandom_range(100, 127));
		return b;
	endfunction

	task automatic add_random(input int n, input int hdr_pct);
		for (int i = 0; i < n; i++)
			add_word($urandom_range(0, 99) < hdr_pct, rand_bits());
	endtask

	initial begin
		logic [31:0] directed[] = '{32'h00000000, 32'h80000000, 32'h7fc00000, 32'hffffffff,
			32'h7f800001, 32'h7f800000, 32'hff800000, 32'h3f800000, 32'hbf800000,
			32'h40000000, 32'h3f000000, 32'h00000001, 32'h007fffff, 32'h7f7fffff,
			32'h33ffffff, 32'h34000000, 32'h34400000, 32'h3f7fffff, 32'hbf7fffff,
			32'h3effffff};
		rate_sh = 20'd48000;
		chan_sh = 7'd2;
		len_sh = 32'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		add_word(1'b1, 32'hffffffff);
		foreach (directed[i]) add_word(1'b0, directed[i]);
		add_word(1'b1, 32'h0);
		drain();
		cfg_write(REG_RATE, 32'd768000);
		cfg_write(REG_CHAN, 32'd64);
		cfg_write(REG_LEN, 32'hffffffff);
		cfg_write(2'd3, 32'h12345678);
		add_word(1'b1, $urandom);
		add_random(50, 5);
		drain();
		cfg_write(REG_RATE, 32'd1);
		cfg_write(REG_CHAN, 32'd1);
		cfg_write(REG_LEN, 32'd0);
		add_word(1'b1, $urandom);
		hold_req++;
		add_random(40, 0);
		drain();
		cfg_write(REG_RATE, 32'hffffffff);
		cfg_write(REG_CHAN, 32'hffffff80);
		cfg_write(REG_LEN, 32'hffffffdc);
		add_word(1'b1, $urandom);
		add_random(50, 5);
		drain();
		cfg_write(REG_RATE, $urandom);
		cfg_write(REG_CHAN, $urandom);
		cfg_write(REG_LEN, $urandom);
		add_random(60, 5);
		add_word(1'b1, $urandom);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && bytes_due.size() == 0) begin
			$display("float_to_pcm24_wav_framer_core_tb: done, clean");
		end else begin
			$display("float_to_pcm24_wav_framer_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("float_to_pcm24_wav_framer_core_tb: done, errors");
		$finish;
	end

endmodule : float_to_pcm24_wav_framer_core_tb
`default_nettype wire
